FILE: rtl/core/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Used by ils_cell and indexed_list_store; depends on nothing.
package ils_pkg;

	// Fixed field widths of the ports
	localparam int OP_W  = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	// Default sizing handed to the top level
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_WORD_WIDTH = 32;

	// Request codes; code 7 is unused and ignored
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_READ   = 3'd4,
		OP_FIND   = 3'd5,
		OP_CLEAR  = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADIDX = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// What every cell of the chain does this cycle
	typedef enum logic [1:0] {
		CA_HOLD   = 2'd0,
		CA_LOAD   = 2'd1,	// write operand at pos only
		CA_INSERT = 2'd2,	// write operand at pos, take left word above pos
		CA_DELETE = 2'd3	// take right word at and above pos
	} cell_act_t;

endpackage

FILE: rtl/core/ils_cell.sv
// One storage cell of the list chain: holds a word, shifts with its neighbours.
// Depends on ils_pkg.
module ils_cell import ils_pkg::*; #(
	parameter int IDX        = 0,
	parameter int CW         = 7,
	parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  cell_act_t             act,
	input  logic [CW-1:0]         pos,
	input  logic [WORD_WIDTH-1:0] operand,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	input  logic [WORD_WIDTH-1:0] search,
	output logic [WORD_WIDTH-1:0] word,
	output logic                  match
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [WORD_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		case (act)
			CA_LOAD: begin
				if (pos == MY_IDX)
					word_q <= operand;
			end
			CA_INSERT: begin
				if (pos == MY_IDX)
					word_q <= operand;
				else if (MY_IDX > pos)
					word_q <= left_word;
			end
			CA_DELETE: begin
				if (MY_IDX >= pos)
					word_q <= right_word;
			end
			default: ;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == search);

endmodule

FILE: rtl/core/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY words in a chain of cells.
// Depends on ils_pkg and ils_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid / in_ready  | operation, position, operand_value
//  out     | source    | out_valid / out_ready| read_value, found_position, list_length,
//          |           |                      | first_element, last_element, status
//
// Flow: one word accepted per cycle unless stalled; it passes the middle stage, and its
// result word is registered in the output register and offered from then until taken.
// The chain of cells applies any shift at the accepting edge; while the word is in the
// middle stage, all cells are scanned at once for read, find and last element.
// Reset: arst_n clears the element count and pipeline valids; the cells
// themselves are not cleared, as only entries below the count are ever seen.
// Stalls: the output register holds while out_ready is low; the middle stage
// then fills and in_ready drops.
module indexed_list_store import ils_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic [POS_W-1:0]        position,
	input  logic [VAL_W-1:0]        operand_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [VAL_W-1:0]        read_value,
	output logic signed [POS_W-1:0] found_position,
	output logic [POS_W-1:0]        list_length,
	output logic [VAL_W-1:0]        first_element,
	output logic [VAL_W-1:0]        last_element,
	output logic [ST_W-1:0]         status
);

	// Count width holds CAPACITY itself; compares run at the wider of count and position
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

	// ---------------- accept stage: status, count and cell command ----------------
	logic                  in_fire;
	op_t                   op_in;
	logic [XW-1:0]         count_x, pos_x;
	logic [WORD_WIDTH-1:0] opnd_in;
	logic [CW-1:0]         count_q, count_d;
	status_t               st_d;
	cell_act_t             act_d, cell_act;
	logic [CW-1:0]         cell_pos;

	assign in_fire = in_valid && in_ready;
	assign op_in   = op_t'(operation);
	assign count_x = XW'(count_q);
	assign pos_x   = XW'(position);
	assign opnd_in = WORD_WIDTH'(operand_value);

	always_comb begin
		st_d     = ST_OK;
		count_d  = count_q;
		act_d    = CA_HOLD;
		cell_pos = CW'(position);	// only used when position <= count
		case (op_in)
			OP_APPEND: begin
				if (count_x >= CAP_X) begin
					st_d = ST_FULL;
				end else begin
					act_d    = CA_LOAD;
					cell_pos = count_q;
					count_d  = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (count_q == '0)
					st_d = ST_EMPTY;
				else
					count_d = count_q - CW'(1);
			end
			OP_INSERT: begin
				// bad index is checked before full
				if (pos_x > count_x) begin
					st_d = ST_BADIDX;
				end else if (count_x >= CAP_X) begin
					st_d = ST_FULL;
				end else begin
					act_d   = CA_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (pos_x >= count_x) begin
					st_d = ST_BADIDX;
				end else begin
					act_d   = CA_DELETE;
					count_d = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (pos_x >= count_x)
					st_d = ST_BADIDX;
			end
			OP_CLEAR: count_d = '0;
			default: ;	// find changes nothing, unused code is ignored
		endcase
	end

	assign cell_act = in_fire ? act_d : CA_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (in_fire)
			count_q <= count_d;
	end

	// ---------------- chain of cells ----------------
	logic [WORD_WIDTH-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]   match;
	logic [WORD_WIDTH-1:0] opnd_s1;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w, right_w;
		if (g == 0) begin : g_head
			assign left_w = opnd_in;	// never taken: cell 0 is never above pos
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_w = words[g];	// tail holds; it lies past the new count
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end
		ils_cell #(
			.IDX        (g),
			.CW         (CW),
			.WORD_WIDTH (WORD_WIDTH)
		) u_cell (
			.clk        (clk),
			.act        (cell_act),
			.pos        (cell_pos),
			.operand    (opnd_in),
			.left_word  (left_w),
			.right_word (right_w),
			.search     (opnd_s1),
			.word       (words[g]),
			.match      (match[g])
		);
	end

	// ---------------- middle stage ----------------
	logic             valid_s1;
	logic             s1_move;
	op_t              op_s1;
	logic [POS_W-1:0] pos_s1;
	status_t          st_s1;
	logic             out_valid_q;

	assign s1_move  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (s1_move)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op_in;
			pos_s1  <= position;
			opnd_s1 <= opnd_in;
			st_s1   <= st_d;
		end
	end

	// Scan of all cells against the count as it stands after this word
	logic [CAPACITY-1:0]   hit, hit_first;
	logic [IW-1:0]         hit_idx;
	logic                  any_hit;
	logic [WORD_WIDTH-1:0] rd_word, last_word;
	logic [CW-1:0]         last_idx;

	assign last_idx  = count_q - CW'(1);	// wraps past every cell when empty
	assign hit_first = hit & (~hit + CAPACITY'(1));
	assign any_hit   = |hit;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			hit[i] = match[i] && (CW'(i) < count_q);
	end

	always_comb begin
		hit_idx   = '0;
		rd_word   = '0;
		last_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_first[i])
				hit_idx = hit_idx | IW'(i);
			if (XW'(pos_s1) == XW'(i))
				rd_word = rd_word | words[i];
			if (last_idx == CW'(i))
				last_word = last_word | words[i];
		end
	end

	// ---------------- output register ----------------
	logic [VAL_W-1:0] read_value_q, first_q, last_q;
	logic [POS_W-1:0] found_q, length_q;
	status_t          status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_move)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_value_q <= (op_s1 == OP_READ && st_s1 == ST_OK) ? VAL_W'(rd_word) : '0;
			found_q      <= (op_s1 == OP_FIND && any_hit) ? POS_W'(hit_idx) : '1;
			length_q     <= POS_W'(count_q);
			first_q      <= (count_q != '0) ? VAL_W'(words[0]) : '0;
			last_q       <= VAL_W'(last_word);
			status_q     <= st_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign found_position = found_q;
	assign list_length    = length_q;
	assign first_element  = first_q;
	assign last_element   = last_q;
	assign status         = status_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op_in == OP_APPEND && count_x < CAP_X |=> count_q == $past(count_q) + CW'(1))
		else $error("good append did not grow the list");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && any_hit |-> CW'(hit_idx) < count_q)
		else $error("find hit beyond the list");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && st_s1 == ST_FULL |-> count_q == CW'(CAPACITY))
		else $error("full status with room left");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(op_s1) && $stable(st_s1))
		else $error("middle stage lost a stalled word");

endmodule
